// File: sv/stdr_pkg.sv
// stdr_pkg: shared types, register codes and defaults of the subframe timing decoder
// no dependencies; used by stdr_color_bank, the decoder unit and the bench
`default_nettype none

package stdr_pkg;

   // table depth default
   localparam int NUM_SUBFRAMES_DEF = 10;

   // command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // register map
   localparam logic [7:0] REG_SUBFRAME_TOTAL = 8'h77;
   localparam logic [7:0] REG_FRC_COLOR0     = 8'h78;
   localparam logic [7:0] REG_FRC_COLOR1     = 8'h79;
   localparam logic [7:0] REG_FRC_COLOR2     = 8'h7A;
   localparam logic [7:0] REG_FRC_PTR        = 8'h7B;
   localparam logic [7:0] REG_FRC_LO         = 8'h7C;
   localparam logic [7:0] REG_FRC_HI         = 8'h7D;
   localparam logic [7:0] REG_LED_COLOR0     = 8'hC0;
   localparam logic [7:0] REG_LED_COLOR1     = 8'hC1;
   localparam logic [7:0] REG_LED_COLOR2     = 8'hC2;
   localparam logic [7:0] REG_LED_PTR        = 8'hC3;
   localparam logic [7:0] REG_LED_LO         = 8'hC4;
   localparam logic [7:0] REG_LED_HI         = 8'hC5;

   // color register groups: four colors per byte
   localparam logic [1:0] GRP_LOW  = 2'd0;
   localparam logic [1:0] GRP_MID  = 2'd1;
   localparam logic [1:0] GRP_HIGH = 2'd2;

   // one table line as held in the line memories
   typedef struct packed {
      logic [15:0] first_row;
      logic [15:0] last_row;
   } line_type;

   localparam int LINE_W = $bits(line_type);

   // color byte write toward a color register bank
   typedef struct packed {
      logic       wr_en;
      logic [1:0] group;
      logic [7:0] value;
   } color_wr_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

endpackage

`default_nettype wire

// File: sv/stdr_line_ram.sv
// stdr_line_ram: one-read one-write line memory with registered read data
// per-entry valid bits make unwritten entries read as zero; does not depend on stdr_pkg
`default_nettype none

module stdr_line_ram #(
   parameter int DEPTH = 10,
   parameter int AW    = 4,
   parameter int WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [WIDTH-1:0] rd_data_ff;

   // storage array, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // valid bits cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // registered read, held while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= vld_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/stdr_color_bank.sv
// stdr_color_bank: 2-bit subframe colors, written four to a byte, read at one index
// depends on stdr_pkg (color_wr_type)
`default_nettype none

module stdr_color_bank #(
   parameter int DEPTH = 10,
   parameter int AW    = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire stdr_pkg::color_wr_type wr,
   input  wire logic [AW-1:0]         rd_index,
   output logic      [1:0]            rd_color
);

   logic [1:0] color_ff [DEPTH];

   // each entry takes its lane of the byte when its group is written
   for (genvar e = 0; e < DEPTH; e++) begin : g_entry
      always_ff @(posedge clock) begin
         if (reset) begin
            color_ff[e] <= 2'd0;
         end else if (wr.wr_en && (wr.group == 2'(e / 4))) begin
            color_ff[e] <= wr.value[2*(e%4) +: 2];
         end
      end
   end

   // read port, zero beyond the table
   assign rd_color = ({1'b0, rd_index} < (AW+1)'(DEPTH)) ? color_ff[rd_index] : 2'd0;

endmodule

`default_nettype wire

// File: sv/subframe_timing_register_decoder_unit.sv
// subframe_timing_register_decoder_unit: register decode, line commit and entry readback
// depends on stdr_pkg, stdr_line_ram and stdr_color_bank
//
// Usage: items arrive on the req_ channel (valid/ready). A write item
// (req_command = 0) updates one register of the subframe timing map and gives no
// result; a read item (req_command = 1) returns the count and one entry of both
// the color-field and LED tables as one beat on the rsp_ channel.
// Each item is handled in turn: the accept edge issues the line memory read
// (the entry needed for a commit, or the entry being read back), and the execute
// state then modifies and writes back or loads the result register. The line
// memories have a registered read, so the block takes a new item only after the
// last one has left its execute state. A read result is loaded into an output
// register in the execute state and held there, so the next item is taken
// while it waits. Only if a second read finds the result register still full
// does the block stall until rsp_ready drains it.
// Reset clears the count, pointers, staging registers, colors and the line
// valid bits, so all tables read as zero right after reset; no clearing pass.
`default_nettype none

module subframe_timing_register_decoder_unit #(
   parameter int NUM_SUBFRAMES = stdr_pkg::NUM_SUBFRAMES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_reg_addr,
   input  wire logic [7:0]  req_write_value,
   input  wire logic [3:0]  req_read_index,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [7:0]  rsp_count_out,
   output logic      [1:0]  rsp_frc_color_out,
   output logic      [15:0] rsp_frc_start_out,
   output logic      [15:0] rsp_frc_end_out,
   output logic      [1:0]  rsp_led_color_out,
   output logic      [15:0] rsp_led_start_out,
   output logic      [15:0] rsp_led_end_out,
   output logic             rsp_index_ok
);

   localparam int AW = (NUM_SUBFRAMES > 1) ? $clog2(NUM_SUBFRAMES) : 1;
   localparam logic [7:0] DEPTH8 = 8'(NUM_SUBFRAMES);

   // sequencer and latched item
   stdr_pkg::state_type state_ff, state_in;
   logic       cmd_ff;
   logic [7:0] addr_ff;
   logic [7:0] value_ff;
   logic [3:0] index_ff;

   // register state
   logic [7:0]  total_ff, total_in;
   logic [7:0]  frc_ptr_ff, frc_ptr_in;
   logic [15:0] frc_stage_ff, frc_stage_in;
   logic [7:0]  led_ptr_ff, led_ptr_in;
   logic [15:0] led_stage_ff, led_stage_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  count_ff;
   logic [1:0]  frc_color_ff, led_color_ff;
   logic [15:0] frc_start_ff, frc_end_ff, led_start_ff, led_end_ff;
   logic        index_ok_ff;

   // memory and bank connections
   logic                    accept;
   logic                    frc_rd_en, led_rd_en;
   logic [AW-1:0]           frc_rd_addr, led_rd_addr;
   logic [stdr_pkg::LINE_W-1:0] frc_rd_raw, led_rd_raw;
   stdr_pkg::line_type      frc_rd, led_rd, frc_wr, led_wr;
   logic                    frc_wr_en, led_wr_en;
   logic [7:0]              ptr_prev;
   logic [7:0]              led_entry;
   logic                    rd_in_range, exec_in_range;
   logic                    exec_write, exec_read, rsp_free;
   stdr_pkg::color_wr_type  frc_cw, led_cw;
   logic [1:0]              frc_color_rd, led_color_rd;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == stdr_pkg::ST_IDLE);

   // read address at accept: commit source line or readback entry
   assign ptr_prev    = frc_ptr_ff - 8'd1;
   assign led_entry   = {1'b0, led_ptr_ff[7:1]};
   assign rd_in_range = ({4'd0, req_read_index} < DEPTH8);

   always_comb begin
      frc_rd_en   = 1'b0;
      led_rd_en   = 1'b0;
      frc_rd_addr = req_read_index[AW-1:0];
      led_rd_addr = req_read_index[AW-1:0];
      if (accept) begin
         if (req_command == stdr_pkg::CMD_READ) begin
            frc_rd_en = rd_in_range;
            led_rd_en = rd_in_range;
         end else begin
            if (req_reg_addr == stdr_pkg::REG_FRC_HI && frc_ptr_ff < DEPTH8) begin
               frc_rd_en   = 1'b1;
               frc_rd_addr = (frc_ptr_ff == 8'd0) ? '0 : ptr_prev[AW-1:0];
            end
            if (req_reg_addr == stdr_pkg::REG_LED_HI && led_entry < DEPTH8) begin
               led_rd_en   = 1'b1;
               led_rd_addr = led_entry[AW-1:0];
            end
         end
      end
   end

   stdr_line_ram #(
      .DEPTH (NUM_SUBFRAMES),
      .AW    (AW),
      .WIDTH (stdr_pkg::LINE_W)
   ) u_frc_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (frc_rd_en),
      .rd_addr (frc_rd_addr),
      .rd_data (frc_rd_raw),
      .wr_en   (frc_wr_en),
      .wr_addr (frc_ptr_ff[AW-1:0]),
      .wr_data (frc_wr)
   );

   stdr_line_ram #(
      .DEPTH (NUM_SUBFRAMES),
      .AW    (AW),
      .WIDTH (stdr_pkg::LINE_W)
   ) u_led_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (led_rd_en),
      .rd_addr (led_rd_addr),
      .rd_data (led_rd_raw),
      .wr_en   (led_wr_en),
      .wr_addr (led_entry[AW-1:0]),
      .wr_data (led_wr)
   );

   assign frc_rd = stdr_pkg::line_type'(frc_rd_raw);
   assign led_rd = stdr_pkg::line_type'(led_rd_raw);

   // execute cycle decode
   assign exec_write    = (state_ff == stdr_pkg::ST_EXEC) && (cmd_ff == stdr_pkg::CMD_WRITE);
   assign exec_read     = (state_ff == stdr_pkg::ST_EXEC) && (cmd_ff == stdr_pkg::CMD_READ);
   assign rsp_free      = !rsp_valid_ff || rsp_ready;
   assign exec_in_range = ({4'd0, index_ff} < DEPTH8);

   // color byte writes
   always_comb begin
      frc_cw.wr_en = 1'b0;
      frc_cw.group = stdr_pkg::GRP_LOW;
      frc_cw.value = value_ff;
      led_cw.wr_en = 1'b0;
      led_cw.group = stdr_pkg::GRP_LOW;
      led_cw.value = value_ff;
      if (exec_write) begin
         case (addr_ff)
            stdr_pkg::REG_FRC_COLOR0: begin
               frc_cw.wr_en = 1'b1;
               frc_cw.group = stdr_pkg::GRP_LOW;
            end
            stdr_pkg::REG_FRC_COLOR1: begin
               frc_cw.wr_en = 1'b1;
               frc_cw.group = stdr_pkg::GRP_MID;
            end
            stdr_pkg::REG_FRC_COLOR2: begin
               frc_cw.wr_en = 1'b1;
               frc_cw.group = stdr_pkg::GRP_HIGH;
            end
            stdr_pkg::REG_LED_COLOR0: begin
               led_cw.wr_en = 1'b1;
               led_cw.group = stdr_pkg::GRP_LOW;
            end
            stdr_pkg::REG_LED_COLOR1: begin
               led_cw.wr_en = 1'b1;
               led_cw.group = stdr_pkg::GRP_MID;
            end
            stdr_pkg::REG_LED_COLOR2: begin
               led_cw.wr_en = 1'b1;
               led_cw.group = stdr_pkg::GRP_HIGH;
            end
            default: begin
            end
         endcase
      end
   end

   stdr_color_bank #(
      .DEPTH (NUM_SUBFRAMES),
      .AW    (AW)
   ) u_frc_color (
      .clock    (clock),
      .reset    (reset),
      .wr       (frc_cw),
      .rd_index (index_ff[AW-1:0]),
      .rd_color (frc_color_rd)
   );

   stdr_color_bank #(
      .DEPTH (NUM_SUBFRAMES),
      .AW    (AW)
   ) u_led_color (
      .clock    (clock),
      .reset    (reset),
      .wr       (led_cw),
      .rd_index (index_ff[AW-1:0]),
      .rd_color (led_color_rd)
   );

   // register updates, commits and line write-back
   always_comb begin
      total_in     = total_ff;
      frc_ptr_in   = frc_ptr_ff;
      frc_stage_in = frc_stage_ff;
      led_ptr_in   = led_ptr_ff;
      led_stage_in = led_stage_ff;
      frc_wr_en    = 1'b0;
      led_wr_en    = 1'b0;
      frc_wr       = frc_rd;
      led_wr       = led_rd;
      if (exec_write) begin
         case (addr_ff)
            stdr_pkg::REG_SUBFRAME_TOTAL: total_in = value_ff;
            stdr_pkg::REG_FRC_PTR: frc_ptr_in = value_ff;
            stdr_pkg::REG_FRC_LO:  frc_stage_in = {frc_stage_ff[15:8], value_ff};
            stdr_pkg::REG_FRC_HI: begin
               frc_stage_in = {value_ff, frc_stage_ff[7:0]};
               frc_ptr_in   = frc_ptr_ff + 8'd1;
               frc_wr_en    = (frc_ptr_ff < DEPTH8);
               // entry 0 keeps its start, others chain from the previous end
               frc_wr.first_row = (frc_ptr_ff == 8'd0) ? frc_rd.first_row
                                                       : frc_rd.last_row;
               frc_wr.last_row  = frc_wr.first_row + frc_stage_in;
            end
            stdr_pkg::REG_LED_PTR: led_ptr_in = value_ff;
            stdr_pkg::REG_LED_LO:  led_stage_in = {led_stage_ff[15:8], value_ff};
            stdr_pkg::REG_LED_HI: begin
               led_stage_in = {value_ff, led_stage_ff[7:0]};
               led_ptr_in   = led_ptr_ff + 8'd1;
               led_wr_en    = (led_entry < DEPTH8);
               // odd pointer writes the end line, even the start line
               if (led_ptr_ff[0]) begin
                  led_wr.last_row = led_stage_in;
               end else begin
                  led_wr.first_row = led_stage_in;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         stdr_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = stdr_pkg::ST_EXEC;
            end
         end
         stdr_pkg::ST_EXEC: begin
            if (exec_write) begin
               state_in = stdr_pkg::ST_IDLE;
            end else if (rsp_free) begin
               state_in     = stdr_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = stdr_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stdr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         frc_ptr_ff   <= '0;
         frc_stage_ff <= '0;
         led_ptr_ff   <= '0;
         led_stage_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         frc_ptr_ff   <= frc_ptr_in;
         frc_stage_ff <= frc_stage_in;
         led_ptr_ff   <= led_ptr_in;
         led_stage_ff <= led_stage_in;
      end
   end

   // latched item fields
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         addr_ff  <= req_reg_addr;
         value_ff <= req_write_value;
         index_ff <= req_read_index;
      end
   end

   // result register load
   always_ff @(posedge clock) begin
      if (exec_read && rsp_free) begin
         count_ff     <= total_ff;
         index_ok_ff  <= exec_in_range;
         frc_color_ff <= exec_in_range ? frc_color_rd : 2'd0;
         led_color_ff <= exec_in_range ? led_color_rd : 2'd0;
         frc_start_ff <= exec_in_range ? frc_rd.first_row : 16'd0;
         frc_end_ff   <= exec_in_range ? frc_rd.last_row : 16'd0;
         led_start_ff <= exec_in_range ? led_rd.first_row : 16'd0;
         led_end_ff   <= exec_in_range ? led_rd.last_row : 16'd0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_count_out     = count_ff;
   assign rsp_frc_color_out = frc_color_ff;
   assign rsp_frc_start_out = frc_start_ff;
   assign rsp_frc_end_out   = frc_end_ff;
   assign rsp_led_color_out = led_color_ff;
   assign rsp_led_start_out = led_start_ff;
   assign rsp_led_end_out   = led_end_ff;
   assign rsp_index_ok      = index_ok_ff;

endmodule

`default_nettype wire

// File: bench/subframe_timing_register_decoder_unit_tb.sv
`timescale 1ns / 1ps
// subframe_timing_register_decoder_unit_tb: self-checking bench for the subframe timing decoder
// depends on stdr_pkg and subframe_timing_register_decoder_unit; tracks both tables in a class

module subframe_timing_register_decoder_unit_tb;

   localparam int NSUB        = stdr_pkg::NUM_SUBFRAMES_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TOTAL_BEATS = 1925;
   localparam int TAIL_BEATS  = 200;
   localparam int LONG_HOLD   = 300;
   localparam int SETTLE      = 20;

   // one readback beat, field order matches the rsp_ port list
   typedef struct packed {
      logic [7:0]  count;
      logic [1:0]  frc_color;
      logic [15:0] frc_start;
      logic [15:0] frc_end;
      logic [1:0]  led_color;
      logic [15:0] led_start;
      logic [15:0] led_end;
      logic        ok;
   } readback_type;

   // mirror of the register map and both subframe tables
   class subframe_tracker_type;
      logic [7:0]   total;
      logic [1:0]   frc_color [NSUB];
      logic [15:0]  frc_start [NSUB];
      logic [15:0]  frc_end   [NSUB];
      logic [1:0]   led_color [NSUB];
      logic [15:0]  led_start [NSUB];
      logic [15:0]  led_end   [NSUB];
      logic [7:0]   frc_ptr;
      logic [7:0]   led_ptr;
      logic [15:0]  frc_stage;
      logic [15:0]  led_stage;
      readback_type readback_q[$];
      int           mismatches;

      function new();
         total     = '0;
         frc_ptr   = '0;
         led_ptr   = '0;
         frc_stage = '0;
         led_stage = '0;
         for (int i = 0; i < NSUB; i++) begin
            frc_color[i] = '0;
            frc_start[i] = '0;
            frc_end[i]   = '0;
            led_color[i] = '0;
            led_start[i] = '0;
            led_end[i]   = '0;
         end
         mismatches = 0;
      endfunction

      // four 2-bit colors per byte, lanes past the table are dropped
      function void load_colors(bit led, int first, int lanes, logic [7:0] v);
         for (int k = 0; k < lanes; k++) begin
            if (first + k < NSUB) begin
               if (led) led_color[first + k] = v[2*k +: 2];
               else     frc_color[first + k] = v[2*k +: 2];
            end
         end
      endfunction

      // chain start to the previous end, end = start + staged length
      function void commit_frc();
         int p;
         p = frc_ptr;
         if (p < NSUB) begin
            if (p > 0) frc_start[p] = frc_end[p-1];
            frc_end[p] = frc_start[p] + frc_stage;
         end
      endfunction

      // even pointer writes the start line, odd the end line
      function void commit_led();
         int e;
         e = led_ptr >> 1;
         if (e < NSUB) begin
            if (led_ptr[0]) led_end[e]   = led_stage;
            else            led_start[e] = led_stage;
         end
      endfunction

      // apply one accepted beat, queue the readback a read will produce
      function void take_beat(logic cmd, logic [7:0] addr, logic [7:0] val, logic [3:0] idx);
         readback_type view;
         if (cmd == stdr_pkg::CMD_READ) begin
            view       = '0;
            view.count = total;
            if (idx < NSUB) begin
               view.frc_color = frc_color[idx];
               view.frc_start = frc_start[idx];
               view.frc_end   = frc_end[idx];
               view.led_color = led_color[idx];
               view.led_start = led_start[idx];
               view.led_end   = led_end[idx];
               view.ok        = 1'b1;
            end
            readback_q.push_back(view);
         end else begin
            case (addr)
               stdr_pkg::REG_SUBFRAME_TOTAL: total = val;
               stdr_pkg::REG_FRC_COLOR0: load_colors(1'b0, 0, 4, val);
               stdr_pkg::REG_FRC_COLOR1: load_colors(1'b0, 4, 4, val);
               stdr_pkg::REG_FRC_COLOR2: load_colors(1'b0, 8, 2, val);
               stdr_pkg::REG_FRC_PTR:    frc_ptr = val;
               stdr_pkg::REG_FRC_LO:     frc_stage[7:0] = val;
               stdr_pkg::REG_FRC_HI: begin
                  frc_stage[15:8] = val;
                  commit_frc();
                  frc_ptr = frc_ptr + 8'd1;
               end
               stdr_pkg::REG_LED_COLOR0: load_colors(1'b1, 0, 4, val);
               stdr_pkg::REG_LED_COLOR1: load_colors(1'b1, 4, 4, val);
               stdr_pkg::REG_LED_COLOR2: load_colors(1'b1, 8, 2, val);
               stdr_pkg::REG_LED_PTR:    led_ptr = val;
               stdr_pkg::REG_LED_LO:     led_stage[7:0] = val;
               stdr_pkg::REG_LED_HI: begin
                  led_stage[15:8] = val;
                  commit_led();
                  led_ptr = led_ptr + 8'd1;
               end
               default: ;
            endcase
         end
      endfunction

      function void report(string what);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", what);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
         if (seen !== want) report($sformatf("%s expected %0h got %0h", name, want, seen));
      endfunction

      // compare a result beat against the oldest pending readback
      function void check_readback(readback_type got);
         readback_type want;
         if (readback_q.size() == 0) begin
            report($sformatf("result beat with nothing pending: %0h", got));
         end else begin
            want = readback_q.pop_front();
            compare_field("count_out",     16'(want.count),     16'(got.count));
            compare_field("frc_color_out", 16'(want.frc_color), 16'(got.frc_color));
            compare_field("frc_start_out", want.frc_start,      got.frc_start);
            compare_field("frc_end_out",   want.frc_end,        got.frc_end);
            compare_field("led_color_out", 16'(want.led_color), 16'(got.led_color));
            compare_field("led_start_out", want.led_start,      got.led_start);
            compare_field("led_end_out",   want.led_end,        got.led_end);
            compare_field("index_ok",      16'(want.ok),        16'(got.ok));
         end
      endfunction
   endclass

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic        req_command     = stdr_pkg::CMD_WRITE;
   logic [7:0]  req_reg_addr    = '0;
   logic [7:0]  req_write_value = '0;
   logic [3:0]  req_read_index  = '0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [7:0]  rsp_count_out;
   logic [1:0]  rsp_frc_color_out;
   logic [15:0] rsp_frc_start_out;
   logic [15:0] rsp_frc_end_out;
   logic [1:0]  rsp_led_color_out;
   logic [15:0] rsp_led_start_out;
   logic [15:0] rsp_led_end_out;
   logic        rsp_index_ok;

   subframe_tracker_type tracker = new();

   int          items_sent  = 0;
   int          hold_asked  = 0;
   bit          tail_phase  = 1'b0;
   bit          calm        = 1'b0;
   int unsigned cycle_count = 0;

   logic [7:0]  color_regs [6] = '{stdr_pkg::REG_FRC_COLOR0, stdr_pkg::REG_FRC_COLOR1,
                                   stdr_pkg::REG_FRC_COLOR2, stdr_pkg::REG_LED_COLOR0,
                                   stdr_pkg::REG_LED_COLOR1, stdr_pkg::REG_LED_COLOR2};

   subframe_timing_register_decoder_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_reg_addr      (req_reg_addr),
      .req_write_value   (req_write_value),
      .req_read_index    (req_read_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_count_out     (rsp_count_out),
      .rsp_frc_color_out (rsp_frc_color_out),
      .rsp_frc_start_out (rsp_frc_start_out),
      .rsp_frc_end_out   (rsp_frc_end_out),
      .rsp_led_color_out (rsp_led_color_out),
      .rsp_led_start_out (rsp_led_start_out),
      .rsp_led_end_out   (rsp_led_end_out),
      .rsp_index_ok      (rsp_index_ok)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("subframe_timing_register_decoder_unit_tb: FAIL");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_readback({rsp_count_out, rsp_frc_color_out, rsp_frc_start_out,
                                 rsp_frc_end_out, rsp_led_color_out, rsp_led_start_out,
                                 rsp_led_end_out, rsp_index_ok});
   end

   // result side: random ready bursts, a long hold on request, always ready at the tail
   initial begin : receiver
      int hold_done;
      int run;
      hold_done = 0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_asked != hold_done) begin
            hold_done = hold_asked;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (tail_phase) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
            rsp_ready <= 1'b1;
            repeat (run) @(posedge clock);
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   task automatic idle_gap(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // offer one beat and hold it until accepted; valid stays high for the caller
   task automatic send_beat(input logic cmd, input logic [7:0] addr, input logic [7:0] val,
                            input logic [3:0] idx);
      if (!tail_phase && !calm && $urandom_range(0, 4) == 0) idle_gap($urandom_range(1, 12));
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_reg_addr    <= addr;
      req_write_value <= val;
      req_read_index  <= idx;
      do @(posedge clock); while (!req_ready);
      tracker.take_beat(cmd, addr, val, idx);
      items_sent++;
   endtask

   // unused fields carry random bits
   task automatic write_beat(input logic [7:0] addr, input logic [7:0] val);
      send_beat(stdr_pkg::CMD_WRITE, addr, val, 4'($urandom));
   endtask

   task automatic read_beat(input logic [3:0] idx);
      send_beat(stdr_pkg::CMD_READ, 8'($urandom), 8'($urandom), idx);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.readback_q.size() != 0);
   endtask

   function automatic logic [7:0] pick_pointer(int span);
      if ($urandom_range(0, 7) == 0) return 8'($urandom);
      return 8'($urandom_range(0, span - 1));
   endfunction

   // stimulus
   initial begin : stimulus
      int  kind;
      int  n;
      bit  pressed;
      bit  paused;
      pressed = 1'b0;
      paused  = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // tables read as zero after reset, in and out of range
      read_beat(4'd0);
      read_beat(4'd15);
      write_beat(stdr_pkg::REG_SUBFRAME_TOTAL, 8'hFF);
      write_beat(stdr_pkg::REG_FRC_COLOR0, 8'hFF);
      write_beat(stdr_pkg::REG_FRC_COLOR1, 8'h1B);
      // color bits past the table are dropped
      write_beat(stdr_pkg::REG_FRC_COLOR2, 8'hFF);
      // entry 0 keeps its start, end is max length
      write_beat(stdr_pkg::REG_FRC_LO, 8'hFF);
      write_beat(stdr_pkg::REG_FRC_HI, 8'hFF);
      // entry 1 chains from entry 0 and wraps at 16 bits
      write_beat(stdr_pkg::REG_FRC_LO, 8'h02);
      write_beat(stdr_pkg::REG_FRC_HI, 8'h00);
      write_beat(stdr_pkg::REG_FRC_PTR, 8'd9);
      write_beat(stdr_pkg::REG_FRC_HI, 8'h80);
      // pointer beyond the table, then wrap from 255 back to entry 0
      write_beat(stdr_pkg::REG_FRC_PTR, 8'hFF);
      write_beat(stdr_pkg::REG_FRC_HI, 8'h12);
      write_beat(stdr_pkg::REG_FRC_HI, 8'h00);
      write_beat(stdr_pkg::REG_LED_COLOR0, 8'hE4);
      write_beat(stdr_pkg::REG_LED_COLOR1, 8'h00);
      write_beat(stdr_pkg::REG_LED_COLOR2, 8'hFF);
      // led start then end of entry 0
      write_beat(stdr_pkg::REG_LED_LO, 8'hFF);
      write_beat(stdr_pkg::REG_LED_HI, 8'hFF);
      write_beat(stdr_pkg::REG_LED_HI, 8'h00);
      // last led slot, then one past the table
      write_beat(stdr_pkg::REG_LED_PTR, 8'd19);
      write_beat(stdr_pkg::REG_LED_HI, 8'hAB);
      write_beat(stdr_pkg::REG_LED_PTR, 8'd20);
      write_beat(stdr_pkg::REG_LED_HI, 8'h01);
      // unknown addresses
      write_beat(8'h00, 8'h55);
      write_beat(8'hFF, 8'hAA);
      read_beat(4'd0);
      read_beat(4'd1);
      read_beat(4'd9);
      read_beat(4'd10);
      wait_drained();

      // random sequences, mostly well-formed register programs
      while (items_sent < TOTAL_BEATS) begin
         if (items_sent >= TOTAL_BEATS - TAIL_BEATS) tail_phase <= 1'b1;
         calm = ($urandom_range(0, 4) == 0);
         if (!pressed && items_sent >= 700) begin
            // hold the result side off and keep offering reads until the input stalls
            pressed = 1'b1;
            calm    = 1'b1;
            hold_asked <= hold_asked + 1;
            repeat (40) read_beat(4'($urandom_range(0, 15)));
         end else if (!paused && items_sent >= 1300) begin
            paused = 1'b1;
            wait_drained();
         end else begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
               // color-field program: pointer, then length pairs
               if ($urandom_range(0, 3) != 0)
                  write_beat(stdr_pkg::REG_FRC_PTR, pick_pointer(NSUB + 2));
               n = $urandom_range(1, 4);
               repeat (n) begin
                  if ($urandom_range(0, 5) != 0) write_beat(stdr_pkg::REG_FRC_LO, 8'($urandom));
                  write_beat(stdr_pkg::REG_FRC_HI, 8'($urandom));
               end
               if ($urandom_range(0, 1) != 0) read_beat(4'($urandom_range(0, NSUB - 1)));
            end else if (kind < 55) begin
               // led program: pointer, then line pairs
               if ($urandom_range(0, 3) != 0)
                  write_beat(stdr_pkg::REG_LED_PTR, pick_pointer(2 * NSUB + 2));
               n = $urandom_range(1, 4);
               repeat (n) begin
                  if ($urandom_range(0, 5) != 0) write_beat(stdr_pkg::REG_LED_LO, 8'($urandom));
                  write_beat(stdr_pkg::REG_LED_HI, 8'($urandom));
               end
               if ($urandom_range(0, 1) != 0) read_beat(4'($urandom_range(0, NSUB - 1)));
            end else if (kind < 65) begin
               write_beat(color_regs[$urandom_range(0, 5)], 8'($urandom));
            end else if (kind < 70) begin
               write_beat(stdr_pkg::REG_SUBFRAME_TOTAL, 8'($urandom));
            end else if (kind < 90) begin
               n = $urandom_range(1, 4);
               repeat (n) begin
                  if ($urandom_range(0, 3) == 0) read_beat(4'($urandom_range(0, 15)));
                  else read_beat(4'($urandom_range(0, NSUB - 1)));
               end
            end else begin
               // noise: any command, any address
               send_beat(1'($urandom), 8'($urandom), 8'($urandom), 4'($urandom));
            end
         end
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("subframe_timing_register_decoder_unit_tb: PASS");
      else
         $display("subframe_timing_register_decoder_unit_tb: FAIL");
      $finish;
   end

endmodule

// File: subframe_timing_register_decoder_unit.f
sv/stdr_pkg.sv
sv/stdr_line_ram.sv
sv/stdr_color_bank.sv
sv/subframe_timing_register_decoder_unit.sv
bench/subframe_timing_register_decoder_unit_tb.sv
